[hw/rtl/sds_pkg.sv]
// Shared types and constants for the SCAN disk scheduler.
`default_nettype none

package sds_pkg;

  // Opcodes of an input beat
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_MOVE    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Configuration register indexes
  localparam logic REG_START_HEAD = 1'b0;
  localparam logic REG_LAST_CYL   = 1'b1;

  // Input beat
  typedef struct packed {
    logic        op;
    logic [15:0] cylinder;
  } sds_in_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] target;
    logic [15:0] seek;
    logic [16:0] total_seek;
    logic        overflow;
    logic        last;
  } sds_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic set_ovf;       // drop a load, flag it
    logic ins_start;     // capture cylinder, insert position = count
    logic ins_new;       // write new request at idx, count grows
    logic ins_shift;     // move read entry up to idx, idx steps down
    logic rd_en;         // read the store
    logic rd_prev;       // read at idx-1 instead of idx
    logic run_start;     // head = start_head, total = 0, idx = 0
    logic idx_inc;
    logic idx_dec;
    logic fu_from_idx;   // first entry at or above start found at idx
    logic fu_all_below;  // every entry below start: fu = count, idx = count-1
    logic idx_from_fu;   // idx = fu-1 for the downward sweep
    logic move_req;      // move head to the read entry
    logic move_end;      // move head to the last cylinder if above
    logic summary;       // emit summary, empty the store
  } sds_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic idx_zero;
    logic idx_last;
    logic fu_zero;
    logic rdata_lt_start;
    logic rdata_gt_cyl;
  } sds_stat_t;

endpackage

`default_nettype wire

[hw/rtl/sds_ctrl.sv]
// Controller state machine for the SCAN disk scheduler.
`default_nettype none

module sds_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              op,
  input  wire sds_pkg::sds_stat_t stat,
  output sds_pkg::sds_cmd_t      cmd,
  output logic                   busy
);
  import sds_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_INS_RD   = 11'b000_0000_0010,
    S_INS_CMP  = 11'b000_0000_0100,
    S_SCAN_RD  = 11'b000_0000_1000,
    S_SCAN_CMP = 11'b000_0001_0000,
    S_UP_RD    = 11'b000_0010_0000,
    S_UP_MOVE  = 11'b000_0100_0000,
    S_END_MOVE = 11'b000_1000_0000,
    S_DN_RD    = 11'b001_0000_0000,
    S_DN_MOVE  = 11'b010_0000_0000,
    S_SUM      = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_LOAD) begin
            if (stat.count_full) begin
              cmd.set_ovf = 1'b1;
            end else begin
              cmd.ins_start = 1'b1;
              state_next    = S_INS_RD;
            end
          end else begin
            cmd.run_start = 1'b1;
            state_next    = stat.count_zero ? S_SUM : S_SCAN_RD;
          end
        end
      end
      // insertion: walk down from the top, shifting larger entries up
      S_INS_RD: begin
        if (stat.idx_zero) begin
          cmd.ins_new = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_prev = 1'b1;
          state_next  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.rdata_gt_cyl) begin
          cmd.ins_shift = 1'b1;
          state_next    = S_INS_RD;
        end else begin
          cmd.ins_new = 1'b1;
          state_next  = S_IDLE;
        end
      end
      // search for the first request at or above the start head
      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat.rdata_lt_start) begin
          if (stat.idx_last) begin
            cmd.fu_all_below = 1'b1;
            state_next       = S_DN_RD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_SCAN_RD;
          end
        end else begin
          cmd.fu_from_idx = 1'b1;
          state_next      = S_UP_RD;
        end
      end
      // upward sweep
      S_UP_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_UP_MOVE;
      end
      S_UP_MOVE: begin
        cmd.move_req = 1'b1;
        if (stat.idx_last) begin
          state_next = stat.fu_zero ? S_SUM : S_END_MOVE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_UP_RD;
        end
      end
      S_END_MOVE: begin
        cmd.move_end    = 1'b1;
        cmd.idx_from_fu = 1'b1;
        state_next      = S_DN_RD;
      end
      // downward sweep
      S_DN_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_DN_MOVE;
      end
      S_DN_MOVE: begin
        cmd.move_req = 1'b1;
        if (stat.idx_zero) begin
          state_next = S_SUM;
        end else begin
          cmd.idx_dec = 1'b1;
          state_next  = S_DN_RD;
        end
      end
      S_SUM: begin
        cmd.summary = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/sds_datapath.sv]
// Datapath of the SCAN disk scheduler: request store, head, totals, result register.
`default_nettype none

module sds_datapath #(
  parameter int MAX_REQ = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sds_pkg::sds_cmd_t  cmd,
  input  wire logic [15:0]        cylinder,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  output sds_pkg::sds_stat_t      stat,
  output sds_pkg::sds_out_t       res,
  output logic                    res_valid
);
  import sds_pkg::*;

  localparam int CW = $clog2(MAX_REQ + 1);
  localparam int AW = (MAX_REQ > 1) ? $clog2(MAX_REQ) : 1;

  logic [15:0]   mem [MAX_REQ];
  logic [15:0]   start_head;
  logic [15:0]   last_cyl;
  logic [CW-1:0] count;
  logic          ovf;
  logic [CW-1:0] idx;
  logic [CW-1:0] fu;
  logic [15:0]   head;
  logic [16:0]   total;
  logic [15:0]   cyl_hold;
  logic [15:0]   rdata;

  logic [CW-1:0] idx_prev;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [15:0]   wr_data;
  logic [15:0]   dest;
  logic [15:0]   seek;
  logic [16:0]   total_sum;
  logic          move_ok;
  logic          emit;

  // Store addressing
  assign idx_prev = idx - CW'(1);
  assign rd_addr  = cmd.rd_prev ? idx_prev[AW-1:0] : idx[AW-1:0];
  assign wr_addr  = idx[AW-1:0];
  assign wr_en    = cmd.ins_new | cmd.ins_shift;
  assign wr_data  = cmd.ins_shift ? rdata : cyl_hold;

  // Request store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Head move: distance and running total
  assign dest      = cmd.move_end ? last_cyl : rdata;
  assign move_ok   = (cmd.move_req && (dest != head)) ||
                     (cmd.move_end && (last_cyl > head));
  assign seek      = (dest > head) ? (dest - head) : (head - dest);
  assign total_sum = total + {1'b0, seek};
  assign emit      = move_ok | cmd.summary;

  // Status
  assign stat.count_zero     = (count == '0);
  assign stat.count_full     = (count == CW'(MAX_REQ));
  assign stat.idx_zero       = (idx == '0);
  assign stat.idx_last       = ((idx + CW'(1)) == count);
  assign stat.fu_zero        = (fu == '0);
  assign stat.rdata_lt_start = (rdata < start_head);
  assign stat.rdata_gt_cyl   = (rdata > cyl_hold);

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_head <= '0;
      last_cyl   <= 16'hFFFF;
      count      <= '0;
      ovf        <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= emit;
      if (cfg_valid) begin
        if (cfg_index == REG_START_HEAD) begin
          start_head <= cfg_data;
        end else begin
          last_cyl <= cfg_data;
        end
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.ins_new) begin
        count <= count + CW'(1);
      end
      if (cmd.summary) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // Walk indexes, head and total
  always_ff @(posedge clk) begin
    if (cmd.ins_start) begin
      cyl_hold <= cylinder;
      idx      <= count;
    end
    if (cmd.ins_shift || cmd.idx_dec) begin
      idx <= idx_prev;
    end
    if (cmd.run_start) begin
      idx   <= '0;
      head  <= start_head;
      total <= '0;
    end
    if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end
    if (cmd.fu_from_idx) begin
      fu <= idx;
    end
    if (cmd.fu_all_below) begin
      fu  <= count;
      idx <= count - CW'(1);
    end
    if (cmd.idx_from_fu) begin
      idx <= fu - CW'(1);
    end
    if (move_ok) begin
      head  <= dest;
      total <= total_sum;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.summary) begin
      res.kind       <= KIND_SUMMARY;
      res.target     <= head;
      res.seek       <= '0;
      res.total_seek <= total;
      res.last       <= 1'b1;
    end else begin
      res.kind       <= cmd.move_end ? KIND_END : KIND_MOVE;
      res.target     <= dest;
      res.seek       <= seek;
      res.total_seek <= total_sum;
      res.last       <= 1'b0;
    end
    res.overflow <= ovf;
  end

endmodule

`default_nettype wire

[hw/rtl/scan_disk_scheduler.sv]
// Top level of the SCAN disk scheduler.
//
// Usage:
//  - Command channel: a beat (item) is taken at a clock edge with start high
//    and busy low. op = load inserts item.cylinder into an ascending store of
//    MAX_REQ entries; op = run schedules all stored requests by SCAN.
//  - A load walks down from the top of the store past each stored entry
//    larger than the new one; each step is a store read then a write. A load
//    into a full store only sets the overflow flag.
//  - A run starts, then reads and compares entries in the search (those below
//    the start head and the first at or above it), reads and moves to each
//    entry swept, turns at the disk end after an upward sweep with entries
//    below, and ends with the summary, paced by the single-port store read.
//  - Results: res_valid strobes for one cycle per beat, in the cycle after
//    the step that made it. The receiver cannot stall; the last beat of a run
//    has last set, after which the store and overflow flag are empty.
//  - Configuration: cfg_ready is always high; index 0 is the start head,
//    index 1 the last cylinder. Write only while the block is idle.
//  - Reset (rst, synchronous) empties the store, clears the overflow flag,
//    sets start head to 0 and last cylinder to 65535.
`default_nettype none

module scan_disk_scheduler #(
  parameter int MAX_REQ = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire sds_pkg::sds_in_t  item,
  output logic                   busy,
  output sds_pkg::sds_out_t      res,
  output logic                   res_valid,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [15:0]       cfg_data
);
  import sds_pkg::*;

  sds_cmd_t  cmd;
  sds_stat_t stat;

  assign cfg_ready = 1'b1;

  sds_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (item.op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sds_datapath #(
    .MAX_REQ (MAX_REQ)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cylinder  (item.cylinder),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .res       (res),
    .res_valid (res_valid)
  );

endmodule

`default_nettype wire

[hw/rtl/sds_checker.sv]
// Port-level checks for the SCAN disk scheduler, bound to the top level.
`default_nettype none

module sds_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire sds_pkg::sds_in_t  item,
  input wire logic              busy,
  input wire sds_pkg::sds_out_t res,
  input wire logic              res_valid
);
  import sds_pkg::*;

  // A move beat is always followed by more of the run, so the block stays busy
  a_move_while_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |-> busy)
    else $error("move beat while idle");

  // The summary beat carries the summary kind and no distance
  a_summary_shape: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last) |-> (res.kind == KIND_SUMMARY && res.seek == '0))
    else $error("malformed summary beat");

  // Every move beat covers a real distance included in the total
  a_move_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |->
      (res.seek != '0 && res.total_seek >= {1'b0, res.seek}))
    else $error("move beat with bad distance");

  // An accepted run keeps the block busy in the next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op == OP_RUN) |=> busy)
    else $error("run accepted but block idle");

endmodule

bind scan_disk_scheduler sds_checker u_sds_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .item      (item),
  .busy      (busy),
  .res       (res),
  .res_valid (res_valid)
);

`default_nettype wire

[sim/scan_disk_scheduler_chk.sv]
// Checker for the SCAN disk scheduler: mirrors the request store and compares result beats.
`default_nettype none

module scan_disk_scheduler_chk #(
  parameter int MAX_REQ = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire sds_pkg::sds_in_t  item,
  input  wire logic              busy,
  input  wire sds_pkg::sds_out_t res,
  input  wire logic              res_valid,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [15:0]       cfg_data,
  output int                     pending,
  output int                     failures
);
  import sds_pkg::*;

  // Mirror of the block's state and registers
  logic [15:0] req_store [MAX_REQ];
  logic [5:0]  req_count;
  logic        dropped;
  logic [15:0] start_head;
  logic [15:0] last_cyl;

  sds_out_t    expected_moves [$];
  int          errs = 0;

  // Sorted insert; equal cylinders go after the ones already stored
  task automatic insert_request(input logic [15:0] cyl);
    int pos;
    if (req_count >= MAX_REQ) begin
      dropped = 1'b1;
    end else begin
      pos = int'(req_count);
      while (pos > 0 && req_store[pos-1] > cyl) begin
        req_store[pos] = req_store[pos-1];
        pos--;
      end
      req_store[pos] = cyl;
      req_count++;
    end
  endtask

  // One head move; a move onto the current head gives no beat
  task automatic push_move(input logic [1:0] kind, input logic [15:0] dest,
                           inout logic [15:0] head, inout logic [16:0] total);
    sds_out_t    beat;
    logic [15:0] step_len;
    if (dest != head) begin
      step_len = (dest > head) ? dest - head : head - dest;
      total    = total + {1'b0, step_len};
      head     = dest;
      beat.kind       = kind;
      beat.target     = dest;
      beat.seek       = step_len;
      beat.total_seek = total;
      beat.overflow   = dropped;
      beat.last       = 1'b0;
      expected_moves.push_back(beat);
    end
  endtask

  // Whole SCAN pass over the store, closed by the summary beat
  task automatic schedule_run();
    int          first_up;
    int          n;
    logic [15:0] head;
    logic [16:0] total;
    sds_out_t    beat;
    head  = start_head;
    total = '0;
    n     = int'(req_count);
    if (n > 0) begin
      first_up = 0;
      while (first_up < n && req_store[first_up] < start_head) first_up++;
      if (start_head <= req_store[n-1]) begin
        // upward sweep, then disk end and back down if anything lies below
        for (int i = first_up; i < n; i++) push_move(KIND_MOVE, req_store[i], head, total);
        if (first_up > 0) begin
          if (last_cyl > head) push_move(KIND_END, last_cyl, head, total);
          for (int i = first_up; i > 0; i--)
            push_move(KIND_MOVE, req_store[i-1], head, total);
        end
      end else begin
        // everything below the head: downward only
        for (int i = n; i > 0; i--) push_move(KIND_MOVE, req_store[i-1], head, total);
      end
    end
    beat.kind       = KIND_SUMMARY;
    beat.target     = head;
    beat.seek       = '0;
    beat.total_seek = total;
    beat.overflow   = dropped;
    beat.last       = 1'b1;
    expected_moves.push_back(beat);
    req_count = '0;
    dropped   = 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  // Compare first, then take config and input beats of the same edge
  always @(posedge clk) begin : monitor
    sds_out_t want;
    if (rst) begin
      req_count  = '0;
      dropped    = 1'b0;
      start_head = 16'd0;
      last_cyl   = 16'hFFFF;
    end else begin
      if (res_valid) begin
        if (expected_moves.size() == 0) begin
          $error("result beat with nothing expected: kind %0d target %0d",
                 res.kind, res.target);
          errs++;
        end else begin
          want = expected_moves.pop_front();
          check_field("kind", want.kind, res.kind);
          check_field("target", want.target, res.target);
          check_field("seek", want.seek, res.seek);
          check_field("total_seek", want.total_seek, res.total_seek);
          check_field("overflow", want.overflow, res.overflow);
          check_field("last", want.last, res.last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_START_HEAD) start_head = cfg_data;
        else                             last_cyl   = cfg_data;
      end
      if (start && !busy) begin
        if (item.op == OP_LOAD) insert_request(item.cylinder);
        else                    schedule_run();
      end
    end
    pending  <= expected_moves.size();
    failures <= errs;
  end

endmodule

`default_nettype wire

[sim/scan_disk_scheduler_tb.sv]
// Testbench top for the SCAN disk scheduler: stimulus, clock, reset and verdict.
`default_nettype none

module scan_disk_scheduler_tb;
  import sds_pkg::*;

  localparam int MAX_REQ   = 32;
  localparam int SETTLE    = 2 * MAX_REQ + 16;  // a load may still be inserting
  localparam int NUM_ITEMS = 310;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  sds_in_t     item      = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = REG_START_HEAD;
  logic [15:0] cfg_data  = '0;
  logic        busy;
  logic        res_valid;
  logic        cfg_ready;
  sds_out_t    res;
  int          pending;
  int          failures;

  // Stimulus-side copy of the registers, to aim cylinders near them
  logic [15:0] head_cfg     = 16'd0;
  logic [15:0] last_cyl_cfg = 16'hFFFF;
  logic [15:0] prev_cyl     = 16'd0;
  bit          burst        = 1'b0;
  int          sent         = 0;

  scan_disk_scheduler #(.MAX_REQ(MAX_REQ)) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .res      (res),
    .res_valid(res_valid),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  scan_disk_scheduler_chk #(.MAX_REQ(MAX_REQ)) chk (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .res      (res),
    .res_valid(res_valid),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pending  (pending),
    .failures (failures)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Command beat; start stays high across back-to-back beats
  task automatic send(input logic op, input logic [15:0] cyl);
    int      gap;
    sds_in_t beat;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.op       = op;
    beat.cylinder = cyl;
    item  <= beat;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Hold off until every result is in and any load has finished
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_START_HEAD) head_cfg = data;
    else                       last_cyl_cfg = data;
  endtask

  // Cylinders bunched at the head, the disk end, the extremes and repeats
  function automatic logic [15:0] pick_cyl();
    logic [15:0] c;
    case ($urandom_range(0, 9))
      0:       c = head_cfg;
      1:       c = head_cfg + 16'($urandom_range(0, 8)) - 16'd4;
      2:       c = last_cyl_cfg;
      3:       c = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      4:       c = prev_cyl;
      default: c = 16'($urandom_range(0, 65535));
    endcase
    prev_cyl = c;
    return c;
  endfunction

  // A batch of loads closed by a run, now and then left open
  task automatic random_batch();
    int loads;
    int sel;
    if ($urandom_range(0, 1) == 0) begin
      drain();
      case ($urandom_range(0, 3))
        0: begin
          cfg_write(REG_START_HEAD, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
          cfg_write(REG_LAST_CYL, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        end
        1: cfg_write(REG_START_HEAD, 16'($urandom_range(0, 65535)));
        2: cfg_write(REG_LAST_CYL, 16'($urandom_range(0, 65535)));
        default: begin
          cfg_write(REG_START_HEAD, 16'($urandom_range(0, 65535)));
          cfg_write(REG_LAST_CYL, 16'($urandom_range(0, 65535)));
        end
      endcase
    end
    burst = ($urandom_range(0, 3) == 0);
    sel   = $urandom_range(0, 9);
    if (sel == 0)      loads = 0;
    else if (sel == 1) loads = $urandom_range(MAX_REQ - 4, MAX_REQ + 4);
    else               loads = $urandom_range(1, 8);
    repeat (loads) send(OP_LOAD, pick_cyl());
    if ($urandom_range(0, 7) != 0) send(OP_RUN, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty store: summary only
    send(OP_RUN, 16'hFFFF);
    // requests on the head, equal entries, the extremes
    send(OP_LOAD, 16'd0);
    send(OP_LOAD, 16'hFFFF);
    send(OP_LOAD, 16'd0);
    send(OP_LOAD, 16'd100);
    send(OP_RUN, 16'd0);
    // upward sweep, disk end, then back down
    drain();
    cfg_write(REG_START_HEAD, 16'd500);
    cfg_write(REG_LAST_CYL, 16'd1000);
    send(OP_LOAD, 16'd100);
    send(OP_LOAD, 16'd600);
    send(OP_LOAD, 16'd800);
    send(OP_LOAD, 16'd300);
    send(OP_RUN, 16'd0);
    // disk end equal to the head after the upward sweep
    drain();
    cfg_write(REG_LAST_CYL, 16'd800);
    send(OP_LOAD, 16'd800);
    send(OP_LOAD, 16'd100);
    send(OP_LOAD, 16'd600);
    send(OP_RUN, 16'd0);
    // disk end below the head
    drain();
    cfg_write(REG_LAST_CYL, 16'd700);
    send(OP_LOAD, 16'd800);
    send(OP_LOAD, 16'd200);
    send(OP_RUN, 16'd0);
    // every request below the start: downward only
    drain();
    cfg_write(REG_START_HEAD, 16'd60000);
    send(OP_LOAD, 16'd10);
    send(OP_LOAD, 16'd20);
    send(OP_RUN, 16'd0);

    while (sent < NUM_ITEMS) random_batch();
    // close any batch left open
    send(OP_RUN, 16'd0);

    drain();
    if (failures == 0) begin
      $display("scan_disk_scheduler_tb: PASS");
    end else begin
      $display("scan_disk_scheduler_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("scan_disk_scheduler_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
